[design/sphere_frustum_cull_macros.svh]
// Assertion macros used by the sphere frustum cull checker.
`ifndef SPHERE_FRUSTUM_CULL_MACROS_SVH
`define SPHERE_FRUSTUM_CULL_MACROS_SVH

// Check a property while out of reset.
`define SFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[design/sfc_pkg.sv]
// Types, codes and constants of the sphere frustum cull block.
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

  localparam int unsigned NUM_PLANES_DEF = 6;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RADIUS_W  = 31;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned SUM_W     = PROD_W + 2;

  localparam logic [DATA_W-1:0] KEYHOLE_RESET = 32'd196608;

  typedef enum logic [1:0] {
    LOC_OUTSIDE   = 2'd0,
    LOC_INTERSECT = 2'd1,
    LOC_INSIDE    = 2'd2
  } sfc_loc_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TEST = 1'b1
  } sfc_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEYHOLE  = 2'd0,
    CFG_CAMERA_X = 2'd1,
    CFG_CAMERA_Y = 2'd2,
    CFG_CAMERA_Z = 2'd3
  } sfc_cfg_e;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } sfc_stage_en_t;

endpackage

`default_nettype wire

[design/sfc_plane.sv]
// One frustum plane: stored plane, distance pipeline and radius compare.
`timescale 1ns / 1ps
`default_nettype none

module sfc_plane #(
  parameter int unsigned FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire sfc_pkg::sfc_stage_en_t        en_i,
  input  wire logic                          wr_en_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    normal_x_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    normal_y_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    normal_z_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    offset_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    center_x_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    center_y_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    center_z_i,
  input  wire logic [sfc_pkg::RADIUS_W-1:0]  radius_i,
  output logic                               below_neg_o,
  output logic                               below_pos_o
);
  import sfc_pkg::*;

  logic signed [DATA_W-1:0] nx_q, ny_q, nz_q, d_q;
  logic signed [PROD_W-1:0] px_d, py_d, pz_d;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [DATA_W-1:0] d1_q;
  logic signed [SUM_W-1:0]  a_d, b_d, a_q, b_q;
  logic signed [SUM_W-1:0]  dist_sum, rpos, rneg;
  logic                     neg_q, pos_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      nx_q <= signed'(normal_x_i);
      ny_q <= signed'(normal_y_i);
      nz_q <= signed'(normal_z_i);
      d_q  <= signed'(offset_i);
    end
  end

  assign px_d = nx_q * signed'(center_x_i);
  assign py_d = ny_q * signed'(center_y_i);
  assign pz_d = nz_q * signed'(center_z_i);

  assign a_d = SUM_W'(px_q) + SUM_W'(py_q);
  assign b_d = SUM_W'(pz_q) + (SUM_W'(d1_q) <<< FRAC_BITS);

  assign rpos     = signed'(SUM_W'(radius_i) << FRAC_BITS);
  assign rneg     = -rpos;
  assign dist_sum = a_q + b_q;

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      d1_q <= d_q;
    end
    if (en_i.en2) begin
      a_q <= a_d;
      b_q <= b_d;
    end
    if (en_i.en3) begin
      neg_q <= dist_sum < rneg;
      pos_q <= dist_sum < rpos;
    end
  end

  assign below_neg_o = neg_q;
  assign below_pos_o = pos_q;

endmodule

`default_nettype wire

[design/sfc_keyhole.sv]
// Keyhole sphere test on squared distances, three register stages.
`timescale 1ns / 1ps
`default_nettype none

module sfc_keyhole (
  input  wire logic                          clk_i,
  input  wire sfc_pkg::sfc_stage_en_t        en_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    keyhole_radius_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    camera_x_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    camera_y_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    camera_z_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    center_x_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    center_y_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]    center_z_i,
  input  wire logic [sfc_pkg::RADIUS_W-1:0]  radius_i,
  output sfc_pkg::sfc_loc_e                  key_o
);
  import sfc_pkg::*;

  logic [DATA_W:0]   dx, dy, dz, k_ext, rk_sum, kr_diff;
  logic [DATA_W-1:0] mx_d, my_d, mz_d;
  logic [DATA_W-1:0] mx_q, my_q, mz_q, rk_q;
  logic [DATA_W-2:0] kr_q;
  logic              kr_pos_d, kr_pos1_q, kr_pos2_q;
  logic [PROD_W-1:0] sqx_q, sqy_q, sqz_q, tout_q, tin_q;
  logic [PROD_W-1:0] sqx_d, sqy_d, sqz_d, tout_d, tin_d;
  logic [SUM_W-1:0]  dist_sq;
  sfc_loc_e          key_d, key_q;

  assign dx = {center_x_i[DATA_W-1], center_x_i} - {camera_x_i[DATA_W-1], camera_x_i};
  assign dy = {center_y_i[DATA_W-1], center_y_i} - {camera_y_i[DATA_W-1], camera_y_i};
  assign dz = {center_z_i[DATA_W-1], center_z_i} - {camera_z_i[DATA_W-1], camera_z_i};

  assign mx_d = dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
  assign my_d = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
  assign mz_d = dz[DATA_W] ? DATA_W'(-dz) : dz[DATA_W-1:0];

  assign k_ext    = {keyhole_radius_i[DATA_W-1], keyhole_radius_i};
  assign rk_sum   = k_ext + (DATA_W+1)'(radius_i);
  assign kr_diff  = k_ext - (DATA_W+1)'(radius_i);
  assign kr_pos_d = !kr_diff[DATA_W] && (kr_diff != '0);

  assign sqx_d  = mx_q * mx_q;
  assign sqy_d  = my_q * my_q;
  assign sqz_d  = mz_q * mz_q;
  assign tout_d = rk_q * rk_q;
  assign tin_d  = kr_q * kr_q;

  assign dist_sq = SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);

  always_comb begin
    if (keyhole_radius_i[DATA_W-1]) begin
      key_d = LOC_OUTSIDE;
    end else if (dist_sq > SUM_W'(tout_q)) begin
      key_d = LOC_OUTSIDE;
    end else if (kr_pos2_q && (dist_sq < SUM_W'(tin_q))) begin
      key_d = LOC_INSIDE;
    end else begin
      key_d = LOC_INTERSECT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      mx_q      <= mx_d;
      my_q      <= my_d;
      mz_q      <= mz_d;
      rk_q      <= rk_sum[DATA_W-1:0];
      kr_q      <= kr_diff[DATA_W-2:0];
      kr_pos1_q <= kr_pos_d;
    end
    if (en_i.en2) begin
      sqx_q     <= sqx_d;
      sqy_q     <= sqy_d;
      sqz_q     <= sqz_d;
      tout_q    <= tout_d;
      tin_q     <= tin_d;
      kr_pos2_q <= kr_pos1_q;
    end
    if (en_i.en3) begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

[design/sphere_frustum_cull.sv]
// Top level of the sphere frustum cull block.
//
// Input channel (in_valid_i / in_ready_o) carries load and test items. A load
// writes one plane (normal and offset) into plane_index_i and gives no result;
// an index at or beyond NUM_PLANES is dropped. A test classifies a sphere
// (center, radius) against the keyhole sphere and the planes.
// Output channel (out_valid_o / out_ready_i) carries one location code per
// test: outside, intersecting or inside.
// Configuration port: keyhole radius and camera position, written with
// cfg_we_i at index cfg_idx_i; write it only while no test is in flight.
// Throughput: one item per cycle while the output is not stalled; each plane
// has its own multipliers, and the four register stages are product, partial
// sum, full sum with compare, and output.
// Reset clears all stage valid bits and loads the register defaults; planes
// hold no value until loaded.
// A stalled receiver holds the output register; stages fill bubbles first and
// in_ready_o drops only once every stage holds a test.
`timescale 1ns / 1ps
`default_nettype none

module sphere_frustum_cull #(
  parameter int unsigned NUM_PLANES = sfc_pkg::NUM_PLANES_DEF,
  parameter int unsigned FRAC_BITS  = sfc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sfc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             action_i,
  input  wire logic [sfc_pkg::IDX_W-1:0]        plane_index_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]       normal_x_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]       normal_y_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]       normal_z_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]       plane_offset_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]       center_x_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]       center_y_i,
  input  wire logic [sfc_pkg::DATA_W-1:0]       center_z_i,
  input  wire logic [sfc_pkg::RADIUS_W-1:0]     radius_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [1:0]                            location_o
);
  import sfc_pkg::*;

  logic [DATA_W-1:0]   keyhole_q, cam_x_q, cam_y_q, cam_z_q;
  logic                in_fire, load_fire, test_fire;
  logic                v1_q, v2_q, v3_q, out_valid_q;
  logic                en4;
  sfc_stage_en_t       en;
  logic [RADIUS_W-1:0] r1_q, r2_q;
  logic [NUM_PLANES-1:0] below_neg, below_pos;
  sfc_loc_e            key;
  sfc_loc_e            loc_d, loc_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyhole_q <= KEYHOLE_RESET;
      cam_x_q   <= '0;
      cam_y_q   <= '0;
      cam_z_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (sfc_cfg_e'(cfg_idx_i))
        CFG_KEYHOLE:  keyhole_q <= cfg_wdata_i;
        CFG_CAMERA_X: cam_x_q   <= cfg_wdata_i;
        CFG_CAMERA_Y: cam_y_q   <= cfg_wdata_i;
        CFG_CAMERA_Z: cam_z_q   <= cfg_wdata_i;
      endcase
    end
  end

  // Stage enables: advance into a stage that is empty or draining
  assign en4     = !out_valid_q || out_ready_i;
  assign en.en3  = !v3_q || en4;
  assign en.en2  = !v2_q || en.en3;
  assign en.en1  = !v1_q || en.en2;

  assign in_ready_o = en.en1;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (sfc_action_e'(action_i) == ACT_LOAD);
  assign test_fire  = in_fire && (sfc_action_e'(action_i) == ACT_TEST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en.en1) v1_q        <= test_fire;
      if (en.en2) v2_q        <= v1_q;
      if (en.en3) v3_q        <= v2_q;
      if (en4)    out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.en1) r1_q  <= radius_i;
    if (en.en2) r2_q  <= r1_q;
    if (en4)    loc_q <= loc_d;
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    sfc_plane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_plane (
      .clk_i       (clk_i),
      .en_i        (en),
      .wr_en_i     (load_fire && (plane_index_i == IDX_W'(p))),
      .normal_x_i  (normal_x_i),
      .normal_y_i  (normal_y_i),
      .normal_z_i  (normal_z_i),
      .offset_i    (plane_offset_i),
      .center_x_i  (center_x_i),
      .center_y_i  (center_y_i),
      .center_z_i  (center_z_i),
      .radius_i    (r2_q),
      .below_neg_o (below_neg[p]),
      .below_pos_o (below_pos[p])
    );
  end

  sfc_keyhole u_keyhole (
    .clk_i            (clk_i),
    .en_i             (en),
    .keyhole_radius_i (keyhole_q),
    .camera_x_i       (cam_x_q),
    .camera_y_i       (cam_y_q),
    .camera_z_i       (cam_z_q),
    .center_x_i       (center_x_i),
    .center_y_i       (center_y_i),
    .center_z_i       (center_z_i),
    .radius_i         (radius_i),
    .key_o            (key)
  );

  always_comb begin
    priority if (key == LOC_INSIDE) begin
      loc_d = LOC_INSIDE;
    end else if (|below_neg) begin
      loc_d = key;
    end else if (|below_pos) begin
      loc_d = LOC_INTERSECT;
    end else begin
      loc_d = LOC_INSIDE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign location_o  = loc_q;

endmodule

`default_nettype wire

[design/sfc_checker.sv]
// Port-level checks of the sphere frustum cull block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_frustum_cull_macros.svh"

module sfc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] location_o
);

  `SFC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(location_o), "result changed or dropped while stalled")
  `SFC_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")
  `SFC_ASSERT(a_ready_when_drain, out_ready_i |-> in_ready_o, "input stalled while output drains")
  `SFC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (.*);

`default_nettype wire
